// ===== src/tree_lca_binary_lifting_unit_defines.svh =====
// Assertion macros for the tree LCA unit.
`ifndef TREE_LCA_BINARY_LIFTING_UNIT_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TLBL_ASSERT_IMP(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TLBL_ASSERT_NXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TLBL_ASSERT_IMP(name, clock, rstn, ante, cons)
`define TLBL_ASSERT_NXT(name, clock, rstn, ante, cons)
`endif

`endif

// ===== src/tlbl_pkg.sv =====
`default_nettype none
package tlbl_pkg;

	localparam int IDW        = 10;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 16;
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 11;

	localparam logic [IDW-1:0] DEPTH_MAX = 10'h3FF;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// floor(log2(d)) for d != 0
	function automatic logic [3:0] flog2(input logic [IDW-1:0] d);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < IDW; i++) begin
			if (d[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/tree_lca_binary_lifting_unit.sv =====
// Lowest common ancestor by binary lifting over a tree held in two on-chip memories: a
// depth store and a jump table with one row of LEVELS ancestors per node. After reset a
// clearing pass zeroes both memories, one row a cycle, with s_axis_tready low. A beat
// with tuser 0 inserts node tdata[9:0] under parent tdata[19:10] (0 makes a root) and
// gives no result; insert parents before children. A beat with tuser 1 asks for the
// common ancestor of the two nodes and returns one result beat. Everything runs through
// one sequencer over the single read port of each memory, one item at a time: an insert
// reads one jump-table row per level; a query reads a row, selects an entry and reads its
// depth per step of its first lifting pass, and reads the rows of both nodes per step of
// its second. A finished result waits in the output register while the next item
// is taken.
`default_nettype none
`include "tree_lca_binary_lifting_unit_defines.svh"
module tree_lca_binary_lifting_unit #(
	parameter int NODES  = tlbl_pkg::NODES_DEF,
	parameter int LEVELS = tlbl_pkg::LEVELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [tlbl_pkg::IN_W-1:0]  s_axis_tdata,  // node_a, node_b, zero pad
	input  wire logic                       s_axis_tuser,  // opcode
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic [tlbl_pkg::OUT_W-1:0]      m_axis_tdata   // ancestor, zero pad
);
	import tlbl_pkg::*;

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = $clog2(LEVELS);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_I_RD   = 5'd2;
	localparam logic [4:0] S_I_WT   = 5'd3;
	localparam logic [4:0] S_I_WR   = 5'd4;
	localparam logic [4:0] S_Q_DX   = 5'd5;
	localparam logic [4:0] S_Q_DY   = 5'd6;
	localparam logic [4:0] S_Q_SW   = 5'd7;
	localparam logic [4:0] S_P1_RJ  = 5'd8;
	localparam logic [4:0] S_P1_RD  = 5'd9;
	localparam logic [4:0] S_P1_CMP = 5'd10;
	localparam logic [4:0] S_Q_CHK  = 5'd11;
	localparam logic [4:0] S_P2_RX  = 5'd12;
	localparam logic [4:0] S_P2_RY  = 5'd13;
	localparam logic [4:0] S_P2_CMP = 5'd14;
	localparam logic [4:0] S_FIN_RD = 5'd15;
	localparam logic [4:0] S_FIN_WT = 5'd16;
	localparam logic [4:0] S_OUT    = 5'd17;

	typedef logic [LEVELS-1:0][IDW-1:0] row_t;

	function automatic logic [IDW-1:0] chk(input logic [IDW-1:0] v);
		return (32'(v) < NODES) ? v : '0;
	endfunction

	function automatic logic [LW-1:0] top_lvl(input logic [IDW-1:0] d);
		logic [3:0] f;
		f = flog2(d);
		if (int'(f) > LEVELS - 1) begin
			return LW'(LEVELS - 1);
		end
		return LW'(f);
	endfunction

	logic [IDW-1:0] dmem [NODES];
	row_t           jmem [NODES];

	logic [4:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic [LW-1:0]  lvl_q;
	logic [IDW-1:0] u_q, cur_q, dn_q;
	logic [IDW-1:0] x_q, y_q, dx_q, dy_q, t_q, jx_q, res_q;
	row_t           row_q;
	logic [IDW-1:0] drd_q;
	row_t           jrd_q;
	logic           m_valid_q;
	logic [IDW-1:0] m_data_q;

	logic [AW-1:0]  daddr, jaddr;
	logic           mem_we;
	logic [AW-1:0]  waddr;
	logic [IDW-1:0] dwdata;
	row_t           jwdata;
	logic           s_acc;
	logic           out_load;
	logic [IDW-1:0] in_a, in_b;
	logic [IDW-1:0] e_ins, t_w, jy_w, dx_sw, dy_sw;
	logic [LW-1:0]  lvl_m1;

	assign in_a   = s_axis_tdata[IDW-1:0];
	assign in_b   = s_axis_tdata[2*IDW-1:IDW];
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
	assign lvl_m1 = LW'(lvl_q - 1'b1);

	assign e_ins = (cur_q == u_q) ? cur_q : chk(jrd_q[lvl_m1]);
	assign t_w   = chk(jrd_q[lvl_q]);
	assign jy_w  = chk(jrd_q[lvl_q]);
	assign dx_sw = (dx_q < drd_q) ? drd_q : dx_q;
	assign dy_sw = (dx_q < drd_q) ? dx_q : drd_q;

	always_comb begin
		daddr  = AW'(cur_q);
		jaddr  = AW'(cur_q);
		mem_we = 1'b0;
		waddr  = AW'(u_q);
		dwdata = dn_q;
		jwdata = row_q;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				dwdata = '0;
				jwdata = '0;
			end
			S_I_WR:   mem_we = 1'b1;
			S_Q_DX:   daddr = AW'(x_q);
			S_Q_DY:   daddr = AW'(y_q);
			S_P1_RJ:  jaddr = AW'(x_q);
			S_P1_RD:  daddr = AW'(t_w);
			S_P2_RX:  jaddr = AW'(x_q);
			S_P2_RY:  jaddr = AW'(y_q);
			S_FIN_RD: jaddr = AW'(x_q);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[waddr] <= dwdata;
			jmem[waddr] <= jwdata;
		end
		drd_q <= dmem[daddr];
		jrd_q <= jmem[jaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			lvl_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						if (s_axis_tuser == OP_QUERY) begin
							x_q     <= chk(in_a);
							y_q     <= chk(in_b);
							state_q <= S_Q_DX;
						end else if (in_a != '0 && 32'(in_a) < NODES) begin
							u_q      <= in_a;
							cur_q    <= chk(in_b);
							row_q[0] <= chk(in_b);
							lvl_q    <= LW'(1);
							state_q  <= S_I_RD;
						end
					end
				end
				S_I_RD: state_q <= S_I_WT;
				S_I_WT: begin
					row_q[lvl_q] <= e_ins;
					cur_q        <= e_ins;
					if (lvl_q == LW'(1)) begin
						dn_q <= (drd_q == DEPTH_MAX) ? DEPTH_MAX : IDW'(drd_q + 1'b1);
					end
					if (lvl_q == LW'(LEVELS - 1)) begin
						state_q <= S_I_WR;
					end else begin
						lvl_q   <= LW'(lvl_q + 1'b1);
						state_q <= S_I_RD;
					end
				end
				S_I_WR: state_q <= S_IDLE;
				S_Q_DX: state_q <= S_Q_DY;
				S_Q_DY: begin
					dx_q    <= drd_q;
					state_q <= S_Q_SW;
				end
				S_Q_SW: begin
					if (dx_q < drd_q) begin
						x_q <= y_q;
						y_q <= x_q;
					end
					dx_q <= dx_sw;
					dy_q <= dy_sw;
					if (dx_sw == '0) begin
						state_q <= S_Q_CHK;
					end else begin
						lvl_q   <= top_lvl(dx_sw);
						state_q <= S_P1_RJ;
					end
				end
				S_P1_RJ: state_q <= S_P1_RD;
				S_P1_RD: begin
					t_q     <= t_w;
					state_q <= S_P1_CMP;
				end
				S_P1_CMP: begin
					if (drd_q >= dy_q) begin
						x_q  <= t_q;
						dx_q <= drd_q;
					end
					if (lvl_q == '0) begin
						state_q <= S_Q_CHK;
					end else begin
						lvl_q   <= lvl_m1;
						state_q <= S_P1_RJ;
					end
				end
				S_Q_CHK: begin
					if (x_q == y_q) begin
						res_q   <= x_q;
						state_q <= S_OUT;
					end else if (dx_q == '0) begin
						state_q <= S_FIN_RD;
					end else begin
						lvl_q   <= top_lvl(dx_q);
						state_q <= S_P2_RX;
					end
				end
				S_P2_RX: state_q <= S_P2_RY;
				S_P2_RY: begin
					jx_q    <= t_w;
					state_q <= S_P2_CMP;
				end
				S_P2_CMP: begin
					if (jx_q != jy_w) begin
						x_q <= jx_q;
						y_q <= jy_w;
					end
					if (lvl_q == '0) begin
						state_q <= S_FIN_RD;
					end else begin
						lvl_q   <= lvl_m1;
						state_q <= S_P2_RX;
					end
				end
				S_FIN_RD: state_q <= S_FIN_WT;
				S_FIN_WT: begin
					res_q   <= chk(jrd_q[0]);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'(m_data_q);

	`TLBL_ASSERT_IMP(a_lvl_range, clk, arst_n, state_q != S_CLR, 32'(lvl_q) <= LEVELS - 1)
	`TLBL_ASSERT_NXT(a_query_start, clk, arst_n, s_acc && s_axis_tuser == OP_QUERY, state_q == S_Q_DX)
	`TLBL_ASSERT_IMP(a_lift_depth, clk, arst_n, state_q == S_P1_RJ, dx_q >= dy_q)
	`TLBL_ASSERT_IMP(a_out_src, clk, arst_n, $rose(m_valid_q), $past(state_q) == S_OUT)

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;
	import tlbl_pkg::*;

	localparam int NODES       = NODES_DEF;
	localparam int LEVELS      = LEVELS_DEF;
	localparam int ITEM_TARGET = 1550;
	localparam int HOLD_AT     = 30;
	localparam int HOLD_LEN    = 300;
	localparam int QUIET_LIMIT = 6000;

	typedef struct {
		logic           op;
		logic [IDW-1:0] a;
		logic [IDW-1:0] b;
	} tree_op_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;  // node_a, node_b, zero pad
	logic              s_axis_tuser = OP_INSERT;  // opcode
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;  // ancestor, zero pad

	tree_lca_binary_lifting_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial forever #1 clk = ~clk;

	logic [IDW-1:0] tree_depth [NODES];
	logic [IDW-1:0] tree_up [NODES][LEVELS];

	tree_op_t       stim_q[$];
	logic [IDW-1:0] ancestor_due[$];
	tree_op_t       cur;
	int             stim_total = 0;
	int             beats_in = 0;
	int             results_seen = 0;
	int             errors = 0;
	int             feed_wait = 0;
	int             feed_burst = 0;
	int             drain_wait = 0;
	int             drain_burst = 0;
	int             quiet_cycles = 0;

	function automatic void graft_node(logic [IDW-1:0] node, logic [IDW-1:0] parent);
		logic [IDW:0] d;
		if (node == '0)
			return;
		d = {1'b0, tree_depth[parent]} + 1'b1;
		tree_depth[node] = (d > DEPTH_MAX) ? DEPTH_MAX : d[IDW-1:0];
		tree_up[node][0] = parent;
		for (int i = 1; i < LEVELS; i++)
			tree_up[node][i] = tree_up[tree_up[node][i-1]][i-1];
	endfunction

	function automatic int top_step(logic [IDW-1:0] d);
		int k;
		k = -1;
		for (int i = 0; i < IDW; i++)
			if (d[i])
				k = i;
		if (k > LEVELS - 1)
			k = LEVELS - 1;
		return k;
	endfunction

	function automatic logic [IDW-1:0] common_ancestor(logic [IDW-1:0] a, logic [IDW-1:0] b);
		logic [IDW-1:0] x, y, t;
		x = a;
		y = b;
		if (tree_depth[x] < tree_depth[y]) begin
			t = x;
			x = y;
			y = t;
		end
		for (int i = top_step(tree_depth[x]); i >= 0; i--) begin
			t = tree_up[x][i];
			if (tree_depth[t] >= tree_depth[y])
				x = t;
		end
		if (x == y)
			return x;
		for (int i = top_step(tree_depth[x]); i >= 0; i--) begin
			if (tree_up[x][i] != tree_up[y][i]) begin
				x = tree_up[x][i];
				y = tree_up[y][i];
			end
		end
		return tree_up[x][0];
	endfunction

	function automatic int draw_pause(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic report_mismatch(input string what, input logic [IDW-1:0] got,
			input logic [IDW-1:0] want);
		$display("tb: %s: got %0d want %0d at result %0d", what, got, want, results_seen);
		errors++;
	endtask

	task automatic add_item(input logic op, input int a, input int b);
		tree_op_t it;
		it.op = op;
		it.a = a[IDW-1:0];
		it.b = b[IDW-1:0];
		stim_q.push_back(it);
	endtask

	function automatic int pick_id(ref int members[$]);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, NODES - 1);
		return members[$urandom_range(0, members.size() - 1)];
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : feed
		int pause;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= OP_INSERT;
			feed_wait = 0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			if (cur.op == OP_QUERY)
				ancestor_due.push_back(common_ancestor(cur.a, cur.b));
			else
				graft_node(cur.a, cur.b);
			beats_in++;
			pause = draw_pause(feed_burst);
			if (pause == 0 && stim_q.size() != 0) begin
				cur = stim_q.pop_front();
				s_axis_tdata <= {{(IN_W - 2*IDW){1'b0}}, cur.b, cur.a};
				s_axis_tuser <= cur.op;
			end else begin
				s_axis_tvalid <= 1'b0;
				feed_wait = pause;
			end
		end else if (!s_axis_tvalid) begin
			if (feed_wait > 0) begin
				feed_wait--;
			end else if (stim_q.size() != 0) begin
				cur = stim_q.pop_front();
				s_axis_tdata <= {{(IN_W - 2*IDW){1'b0}}, cur.b, cur.a};
				s_axis_tuser <= cur.op;
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// receiver; wait counts only while a result beat is pending
	always @(posedge clk or negedge arst_n) begin : drain
		logic [IDW-1:0] want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			drain_wait = 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (ancestor_due.size() == 0) begin
				report_mismatch("unexpected result beat", m_axis_tdata[IDW-1:0], '0);
			end else begin
				want = ancestor_due.pop_front();
				if (m_axis_tdata[IDW-1:0] !== want)
					report_mismatch("ancestor", m_axis_tdata[IDW-1:0], want);
			end
			drain_wait = (results_seen == HOLD_AT) ? HOLD_LEN : draw_pause(drain_burst);
			if (drain_wait != 0)
				m_axis_tready <= 1'b0;
		end else if (!m_axis_tready && m_axis_tvalid) begin
			if (drain_wait > 0)
				drain_wait--;
			else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int order[NODES-1];
		int members[$];
		int tmp, j, n, last, tree_size;
		bit taken;

		for (int i = 0; i < NODES; i++) begin
			tree_depth[i] = '0;
			for (int k = 0; k < LEVELS; k++)
				tree_up[i][k] = '0;
		end

		// directed
		add_item(OP_QUERY, 0, 0);
		add_item(OP_QUERY, 1023, 5);
		add_item(OP_INSERT, 0, 5);
		add_item(OP_INSERT, 1, 0);
		add_item(OP_INSERT, 2, 1);
		add_item(OP_INSERT, 3, 1);
		add_item(OP_INSERT, 4, 2);
		add_item(OP_INSERT, 1023, 4);
		add_item(OP_QUERY, 4, 3);
		add_item(OP_QUERY, 1023, 3);
		add_item(OP_QUERY, 2, 1023);
		add_item(OP_QUERY, 1023, 1023);
		add_item(OP_QUERY, 0, 1023);
		add_item(OP_QUERY, 1023, 500);
		add_item(OP_INSERT, 10, 0);
		add_item(OP_QUERY, 10, 4);
		add_item(OP_INSERT, 20, 21);
		add_item(OP_INSERT, 21, 1);
		add_item(OP_QUERY, 20, 4);
		add_item(OP_INSERT, 2, 3);
		add_item(OP_QUERY, 4, 3);
		add_item(OP_INSERT, 682, 341);
		add_item(OP_QUERY, 341, 682);

		// one chain through every node in random order, deep enough to saturate
		for (int i = 0; i < NODES - 1; i++)
			order[i] = i + 1;
		for (int i = NODES - 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int k = 0; k < NODES - 1; k++) begin
			add_item(OP_INSERT, order[k], (k == 0) ? 0 : order[k-1]);
			if ($urandom_range(0, 9) == 0)
				add_item(OP_QUERY, order[$urandom_range(0, k)], order[$urandom_range(0, k)]);
		end
		last = order[NODES-2];
		add_item(OP_QUERY, last, order[0]);
		add_item(OP_INSERT, order[5], last);
		add_item(OP_INSERT, last, last);
		for (int k = 0; k < 60; k++)
			add_item(OP_QUERY, order[$urandom_range(0, NODES - 2)],
				($urandom_range(0, 5) == 0) ? $urandom_range(0, NODES - 1)
					: order[$urandom_range(0, NODES - 2)]);

		// small trees rebuilt over the old entries
		while (stim_q.size() < ITEM_TARGET) begin
			members.delete();
			tree_size = $urandom_range(3, 40);
			n = $urandom_range(1, NODES - 1);
			members.push_back(n);
			add_item(OP_INSERT, n, ($urandom_range(0, 5) == 0) ? $urandom_range(0, NODES - 1) : 0);
			while (members.size() < tree_size) begin
				n = $urandom_range(1, NODES - 1);
				taken = 0;
				foreach (members[m])
					if (members[m] == n)
						taken = 1;
				if (!taken) begin
					add_item(OP_INSERT, n, $urandom_range(0, 1) ? members[members.size() - 1]
						: members[$urandom_range(0, members.size() - 1)]);
					members.push_back(n);
				end
				if ($urandom_range(0, 11) == 0)
					add_item(1'($urandom_range(0, 1)), $urandom_range(0, NODES - 1),
						$urandom_range(0, NODES - 1));
			end
			for (int k = 0; k <= tree_size / 2; k++)
				add_item(OP_QUERY, pick_id(members), pick_id(members));
		end
		stim_total = stim_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (beats_in != stim_total || ancestor_due.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
